@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the bound checker of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TPQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpq assertion failed");

// Next-cycle implication.
`define TPQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpq assertion failed");

`endif

@@ hw/rtl/tpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

   localparam int DEFAULT_DEPTH = 16;

   localparam int ID_W     = 22;
   localparam int AGE_W    = 7;
   localparam int TICKET_W = 32;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic [AGE_W-1:0]    CHILD_LIMIT_RESET = 7'd10;
   localparam logic [TICKET_W-1:0] FIRST_TICKET      = 32'd1;

   localparam logic FUNC_ENQ   = 1'b0;
   localparam logic FUNC_SERVE = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_ENQUEUED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_ISSUED   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHILD_LIMIT = 1'b0;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [AGE_W-1:0] age;
      logic             vip;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     ticket_client;
      logic [TICKET_W-1:0] ticket_number;
      logic                ticket_vip;
      logic                ticket_child;
      logic [TIME_W-1:0]   issue_seconds;
      logic [OCC_W-1:0]    occupancy;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/tpq_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface tpq_req_if;
   import tpq_pkg::*;

   logic             valid;
   logic             ready;
   logic             func;
   logic [ID_W-1:0]  client_id;
   logic [AGE_W-1:0] client_age;
   logic             vip_request;
   logic [TIME_W-1:0] now_seconds;

   modport source (output valid, func, client_id, client_age, vip_request, now_seconds,
                   input ready);
   modport sink   (input valid, func, client_id, client_age, vip_request, now_seconds,
                   output ready);
endinterface

interface tpq_rsp_if;
   import tpq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     ticket_client;
   logic [TICKET_W-1:0] ticket_number;
   logic                ticket_vip;
   logic                ticket_child;
   logic [TIME_W-1:0]   issue_seconds;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, status, ticket_client, ticket_number, ticket_vip,
                   ticket_child, issue_seconds, occupancy, input ready);
   modport sink   (input valid, status, ticket_client, ticket_number, ticket_vip,
                   ticket_child, issue_seconds, occupancy, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tpq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tpq_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpq_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [tpq_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [tpq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [tpq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   output logic      [tpq_pkg::AGE_W-1:0]      child_limit
);
   import tpq_pkg::*;

   logic [AGE_W-1:0]     limit_ff;
   logic [AGE_W-1:0]     limit_in;
   logic [CSR_IDX_W-1:0] reg_idx;

   // word index: byte address over four
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && (reg_idx == CSR_CHILD_LIMIT)) begin
         limit_in = pwdata[AGE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CHILD_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata      = (reg_idx == CSR_CHILD_LIMIT) ? CSR_DATA_W'(limit_ff) : '0;
   assign pready      = 1'b1;
   assign child_limit = limit_ff;

endmodule

`default_nettype wire

@@ hw/rtl/two_class_priority_ticket_queue_core.sv @@
// Serve or regular enqueue: IDLE accepts, SERVE or PLACE builds the result word, FINISH
// loads it; full reject or empty serve go straight to FINISH; VIP enqueue behind N > 0
// regulars: PRIME, a SHIFT per regular moving one entry per cycle through the RAM, then
// PLACE and FINISH. One item in flight; a stalled result word holds the finish step and
// the next accept. Synchronous active-high reset empties the queue, sets the next ticket
// to 1 and the child age limit to 10; the entry RAM is not cleared and needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module two_class_priority_ticket_queue_core #(
   parameter int QUEUE_DEPTH = tpq_pkg::DEFAULT_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tpq_req_if.sink                             req,
   tpq_rsp_if.source                           rsp,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [tpq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [tpq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [tpq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import tpq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int OW = (CW > OCC_W) ? CW : OCC_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SERVE  = 3'd1;
   localparam logic [2:0] ST_PRIME  = 3'd2;
   localparam logic [2:0] ST_SHIFT  = 3'd3;
   localparam logic [2:0] ST_PLACE  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]          state_ff,   state_in;
   logic [AW-1:0]       head_ff,    head_in;
   logic [CW-1:0]       count_ff,   count_in;
   logic [CW-1:0]       vip_cnt_ff, vip_cnt_in;
   logic [CW-1:0]       cursor_ff,  cursor_in;
   logic [CW-1:0]       place_ff,   place_in;
   entry_type           entry_ff,   entry_in;
   logic [TIME_W-1:0]   now_ff,     now_in;
   logic [TICKET_W-1:0] ticket_ff,  ticket_in;
   result_type          pend_ff,    pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff,  rsp_data_in;

   logic               accept;
   logic               rsp_load;
   logic [CW-1:0]      cursor_dec;
   entry_type          rd_entry;
   logic [AGE_W-1:0]   child_limit;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [AW-1:0]      ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;

   // logical queue position to RAM address (circular buffer from head)
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [CW-1:0] ofs);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(ofs);
      if (sum >= SW'(QUEUE_DEPTH)) begin
         sum = sum - SW'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [OCC_W-1:0] to_occ(input logic [CW-1:0] c);
      logic [OW-1:0] w;
      w = OW'(c);
      return w[OCC_W-1:0];
   endfunction

   tpq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .child_limit (child_limit)
   );

   tpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req.ready  = (state_ff == ST_IDLE) && !reset;
   assign accept     = req.valid && req.ready;
   assign rd_entry   = entry_type'(ram_rdata);
   assign cursor_dec = cursor_ff - CW'(1);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      vip_cnt_in = vip_cnt_ff;
      cursor_in  = cursor_ff;
      place_in   = place_ff;
      entry_in   = entry_ff;
      now_in     = now_ff;
      ticket_in  = ticket_ff;
      pend_in    = pend_ff;
      rsp_load   = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = phys(head_ff, place_ff);
      ram_wdata  = entry_ff;
      // idle reads keep the head entry ready for a serve
      ram_raddr  = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               entry_in = '{id: req.client_id, age: req.client_age, vip: req.vip_request};
               now_in   = req.now_seconds;
               pend_in  = '0;
               if (req.func == FUNC_ENQ) begin
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     pend_in.status    = STAT_FULL;
                     pend_in.occupancy = to_occ(count_ff);
                     state_in          = ST_FINISH;
                  end else if (!req.vip_request) begin
                     place_in = count_ff;
                     state_in = ST_PLACE;
                  end else begin
                     // VIP goes right behind the VIP block; push regulars back
                     place_in  = vip_cnt_ff;
                     cursor_in = count_ff;
                     state_in  = (count_ff > vip_cnt_ff) ? ST_PRIME : ST_PLACE;
                  end
               end else begin
                  if (count_ff == '0) begin
                     pend_in.status    = STAT_EMPTY;
                     pend_in.occupancy = to_occ(count_ff);
                     state_in          = ST_FINISH;
                  end else begin
                     state_in = ST_SERVE;
                  end
               end
            end
         end
         ST_SERVE: begin
            pend_in.status        = STAT_ISSUED;
            pend_in.ticket_client = rd_entry.id;
            pend_in.ticket_number = ticket_ff;
            pend_in.ticket_vip    = rd_entry.vip;
            pend_in.ticket_child  = (rd_entry.age < child_limit);
            pend_in.issue_seconds = now_ff;
            pend_in.occupancy     = to_occ(count_ff - CW'(1));
            head_in               = phys(head_ff, CW'(1));
            count_in              = count_ff - CW'(1);
            if (rd_entry.vip) begin
               vip_cnt_in = vip_cnt_ff - CW'(1);
            end
            ticket_in = ticket_ff + TICKET_W'(1);
            state_in  = ST_FINISH;
         end
         ST_PRIME: begin
            ram_raddr = phys(head_ff, cursor_dec);
            state_in  = ST_SHIFT;
         end
         ST_SHIFT: begin
            // move entry cursor-1 up to cursor, fetch the one below meanwhile
            ram_we    = 1'b1;
            ram_waddr = phys(head_ff, cursor_ff);
            ram_wdata = ram_rdata;
            cursor_in = cursor_dec;
            if (cursor_dec > vip_cnt_ff) begin
               ram_raddr = phys(head_ff, cursor_ff - CW'(2));
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            ram_we            = 1'b1;
            ram_waddr         = phys(head_ff, place_ff);
            ram_wdata         = entry_ff;
            count_in          = count_ff + CW'(1);
            vip_cnt_in        = vip_cnt_ff + CW'(entry_ff.vip);
            pend_in.status    = STAT_ENQUEUED;
            pend_in.occupancy = to_occ(count_ff + CW'(1));
            state_in          = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in  = pend_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         vip_cnt_ff   <= '0;
         ticket_ff    <= FIRST_TICKET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         vip_cnt_ff   <= vip_cnt_in;
         ticket_ff    <= ticket_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff   <= cursor_in;
      place_ff    <= place_in;
      entry_ff    <= entry_in;
      now_ff      <= now_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_data_ff.status;
   assign rsp.ticket_client = rsp_data_ff.ticket_client;
   assign rsp.ticket_number = rsp_data_ff.ticket_number;
   assign rsp.ticket_vip    = rsp_data_ff.ticket_vip;
   assign rsp.ticket_child  = rsp_data_ff.ticket_child;
   assign rsp.issue_seconds = rsp_data_ff.issue_seconds;
   assign rsp.occupancy     = rsp_data_ff.occupancy;

endmodule

`default_nettype wire

@@ hw/rtl/tpq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tpq_checker #(
   parameter int QUEUE_DEPTH = tpq_pkg::DEFAULT_DEPTH
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [tpq_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [tpq_pkg::TICKET_W-1:0] rsp_ticket_number,
   input wire logic [tpq_pkg::OCC_W-1:0]    rsp_occupancy
);
   import tpq_pkg::*;

   localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

   // stalled result word holds
   `TPQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_occupancy))

   // one item at a time: the block drops ready right after taking a word
   `TPQ_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   `TPQ_ASSERT_IMP(a_empty_result, clock, reset, rsp_valid && (rsp_status == STAT_EMPTY),
      (rsp_occupancy == '0) && (rsp_ticket_number == '0))

   `TPQ_ASSERT_IMP(a_full_result, clock, reset, rsp_valid && (rsp_status == STAT_FULL),
      rsp_occupancy == FULL_OCC)

endmodule

bind two_class_priority_ticket_queue_core tpq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tpq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_ticket_number (rsp.ticket_number),
   .rsp_occupancy     (rsp.occupancy)
);

`default_nettype wire

@@ tb/tpq_ticket_checker.sv @@
`timescale 1ns / 1ps

module tpq_ticket_checker
   import tpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   tpq_req_if                    req,
   tpq_rsp_if                    rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   output int                    mismatch_count,
   output int                    words_pending
);

   localparam logic [CSR_ADDR_W-1:0] CHILD_LIMIT_ADDR = {CSR_CHILD_LIMIT, 2'b00};

   entry_type           lineup [QUEUE_DEPTH];
   int                  lineup_len;
   logic [TICKET_W-1:0] ticket_ctr;
   logic [AGE_W-1:0]    child_limit;
   result_type          due_words [$];

   function automatic result_type predict_word(input logic fn,
                                               input logic [ID_W-1:0] c_id,
                                               input logic [AGE_W-1:0] c_age,
                                               input logic c_vip,
                                               input logic [TIME_W-1:0] stamp);
      result_type word;
      int         pos;
      word = '0;
      if (fn == FUNC_ENQ) begin
         if (lineup_len >= QUEUE_DEPTH) begin
            word.status = STAT_FULL;
         end else begin
            // VIP lands behind the last VIP, regular at the tail
            pos = lineup_len;
            if (c_vip) begin
               pos = 0;
               while (pos < lineup_len && lineup[pos].vip) pos++;
            end
            for (int i = lineup_len; i > pos; i--) lineup[i] = lineup[i-1];
            lineup[pos] = '{id: c_id, age: c_age, vip: c_vip};
            lineup_len++;
            word.status = STAT_ENQUEUED;
         end
      end else if (lineup_len == 0) begin
         word.status = STAT_EMPTY;
      end else begin
         word.status        = STAT_ISSUED;
         word.ticket_client = lineup[0].id;
         word.ticket_number = ticket_ctr;
         word.ticket_vip    = lineup[0].vip;
         word.ticket_child  = (lineup[0].age < child_limit);
         word.issue_seconds = stamp;
         ticket_ctr++;
         for (int i = 0; i + 1 < lineup_len; i++) lineup[i] = lineup[i+1];
         lineup_len--;
      end
      word.occupancy = OCC_W'(lineup_len);
      return word;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         lineup_len  = 0;
         ticket_ctr  = FIRST_TICKET;
         child_limit = CHILD_LIMIT_RESET;
         due_words.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == CHILD_LIMIT_ADDR) begin
            if (csr_pwrite) child_limit = csr_pwdata[AGE_W-1:0];
            else check_field("child_age_limit", 32'(child_limit), csr_prdata);
         end
         // pop before push: a word leaving now never belongs to an item taken now
         if (rsp.valid && rsp.ready) begin
            if (due_words.size() == 0) begin
               $error("result word with no expectation pending");
               mismatch_count++;
            end else begin
               want = due_words.pop_front();
               check_field("status", 32'(want.status), 32'(rsp.status));
               check_field("ticket_client", 32'(want.ticket_client), 32'(rsp.ticket_client));
               check_field("ticket_number", want.ticket_number, rsp.ticket_number);
               check_field("ticket_vip", 32'(want.ticket_vip), 32'(rsp.ticket_vip));
               check_field("ticket_child", 32'(want.ticket_child), 32'(rsp.ticket_child));
               check_field("issue_seconds", want.issue_seconds, rsp.issue_seconds);
               check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
            end
         end
         if (req.valid && req.ready)
            due_words.push_back(predict_word(req.func, req.client_id, req.client_age,
                                             req.vip_request, req.now_seconds));
      end
      words_pending <= due_words.size();
   end

endmodule

@@ tb/tb_two_class_priority_ticket_queue_core.sv @@
`timescale 1ns / 1ps

module tb_two_class_priority_ticket_queue_core;
   import tpq_pkg::*;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int ITEMS_PER_PHASE = 180;
   localparam int DRAIN_CYCLES    = 24;
   localparam logic [ID_W-1:0]       ID_MAX           = '1;
   localparam logic [CSR_ADDR_W-1:0] CHILD_LIMIT_ADDR = {CSR_CHILD_LIMIT, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic                  csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   int                    mismatch_count;
   int                    words_pending;
   int                    cycle_count  = 0;
   int                    snd_idle_pct = 0;
   int                    rcv_idle_pct = 0;

   tpq_req_if req ();
   tpq_rsp_if rsp ();

   two_class_priority_ticket_queue_core dut (
      .clock,
      .reset,
      .req         (req),
      .rsp         (rsp),
      .csr_psel,
      .csr_penable,
      .csr_pwrite,
      .csr_paddr,
      .csr_pwdata,
      .csr_prdata,
      .csr_pready
   );

   tpq_ticket_checker ticket_watch (
      .clock,
      .reset,
      .req            (req),
      .rsp            (rsp),
      .csr_psel,
      .csr_penable,
      .csr_pwrite,
      .csr_pready,
      .csr_paddr,
      .csr_pwdata,
      .csr_prdata,
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[two_class_priority_ticket_queue_core] ERROR");
         $finish;
      end
   end

   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   task automatic send_item(input logic fn, input logic [ID_W-1:0] c_id,
                            input logic [AGE_W-1:0] c_age, input logic c_vip,
                            input logic [TIME_W-1:0] stamp);
      while ($urandom_range(99) < snd_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.func        <= fn;
      req.client_id   <= c_id;
      req.client_age  <= c_age;
      req.vip_request <= c_vip;
      req.now_seconds <= stamp;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // hold the sender until every expected word is back and the core has settled
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CHILD_LIMIT_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_child_limit(input logic [CSR_DATA_W-1:0] limit);
      csr_access(1'b1, limit);
      csr_access(1'b0, '0);
   endtask

   task automatic random_phase(input int snd_pct, input int rcv_pct);
      int enq_pct;
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      enq_pct      = 50;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
         // swing between filling and emptying so full and empty both recur
         if (n % 16 == 0) begin
            case ($urandom_range(2))
               0: enq_pct = 85;
               1: enq_pct = 15;
               default: enq_pct = 55;
            endcase
         end
         if (n == ITEMS_PER_PHASE / 2) drain();
         send_item(($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_SERVE,
                   ID_W'($urandom()), AGE_W'($urandom()), $urandom_range(99) < 40,
                   TIME_W'($urandom()));
      end
   endtask

   initial begin
      logic [AGE_W-1:0] probe_ages [5];
      probe_ages = '{7'd0, 7'd127, 7'd9, 7'd10, 7'd11};
      reset           <= 1'b1;
      req.valid       <= 1'b0;
      req.func        <= FUNC_ENQ;
      req.client_id   <= '0;
      req.client_age  <= '0;
      req.vip_request <= 1'b0;
      req.now_seconds <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty serve, fill with mixed classes, overflow, then serve a few heads
      send_item(FUNC_SERVE, '0, '0, 1'b0, '1);
      for (int i = 0; i < DEFAULT_DEPTH; i++)
         send_item(FUNC_ENQ, (i % 2 != 0) ? ID_MAX - ID_W'(i) : ID_W'(i), probe_ages[i % 5],
                   i % 3 == 1, (i % 2 != 0) ? '1 : '0);
      send_item(FUNC_ENQ, ID_MAX, '1, 1'b1, '1);
      send_item(FUNC_SERVE, ID_MAX, '1, 1'b1, '0);
      send_item(FUNC_SERVE, '0, '0, 1'b0, '1);
      send_item(FUNC_SERVE, '0, '0, 1'b0, 32'h8000_0000);
      send_item(FUNC_SERVE, '0, '0, 1'b0, TIME_W'($urandom()));
      send_item(FUNC_SERVE, '0, '0, 1'b0, TIME_W'($urandom()));
      drain();

      set_child_limit('0);
      random_phase(17, 58);
      drain();
      set_child_limit(CSR_DATA_W'(127));
      random_phase(58, 17);
      drain();
      set_child_limit(CSR_DATA_W'($urandom_range(1, 126)));
      random_phase(0, 0);
      drain();

      if (mismatch_count == 0 && words_pending == 0)
         $display("[two_class_priority_ticket_queue_core] OK");
      else
         $display("[two_class_priority_ticket_queue_core] ERROR");
      $finish;
   end

endmodule
